>>> hdl/tpc_pkg.sv
package tpc_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int FRACTION_BITS = 12;
    localparam int QUEUE_DEPTH   = 4;

    // accumulators wrap modulo 2^64
    localparam int ACC_W    = 64;
    localparam int INDEX_W  = 24;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SUPPORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SATURATED  = 2'd2;

    localparam logic signed [INDEX_W-1:0] INDEX_MAX = {1'b0, {(INDEX_W-1){1'b1}}};
    localparam logic signed [INDEX_W-1:0] INDEX_MIN = {1'b1, {(INDEX_W-1){1'b0}}};

    typedef struct packed {
        logic skip;
        logic last;
    } t_flags;

endpackage

>>> hdl/tpc_front.sv
module tpc_front #(
    parameter int SAMPLE_WIDTH = tpc_pkg::SAMPLE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] i_image_value,
    input  logic signed [SAMPLE_WIDTH-1:0] i_mean_value,
    input  logic signed [SAMPLE_WIDTH-1:0] i_first_component,
    input  logic signed [SAMPLE_WIDTH-1:0] i_second_component,
    input  logic                           i_skip_voxel,
    input  logic                           i_last_voxel,
    output logic                           o_push,
    input  logic                           i_queue_full,
    output logic [2*SAMPLE_WIDTH+1:0]      o_push_data,
    output tpc_pkg::t_flags                o_push_flags
);

    localparam int RES_W = SAMPLE_WIDTH + 2;

    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_pc1;
    logic signed [RES_W-1:0]        r_resid;
    tpc_pkg::t_flags                r_flags;
    logic                           accept;
    logic signed [RES_W-1:0]        n_resid;

    assign o_in_ready = !r_valid || !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_valid && !i_queue_full;

    // residual is exact at two extra bits
    assign n_resid = RES_W'(i_image_value) - RES_W'(i_mean_value)
                   - RES_W'(i_second_component);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pc1        <= i_first_component;
            r_resid      <= n_resid;
            r_flags.skip <= i_skip_voxel;
            r_flags.last <= i_last_voxel;
        end
    end

    assign o_push_data  = {r_pc1, r_resid};
    assign o_push_flags = r_flags;

endmodule

>>> hdl/tpc_queue.sv
module tpc_queue #(
    parameter int DATA_W = 34,
    parameter int DEPTH  = tpc_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [DATA_W-1:0]     i_data,
    input  tpc_pkg::t_flags       i_flags,
    output logic                  o_full,
    output logic                  o_valid,
    input  logic                  i_pop,
    output logic [DATA_W-1:0]     o_data,
    output tpc_pkg::t_flags       o_flags
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0]     r_data [DEPTH];
    tpc_pkg::t_flags       r_flags [DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [CNT_W-1:0]      r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_data[r_rd_ptr];
    assign o_flags = r_flags[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wr_ptr]  <= i_data;
            r_flags[r_wr_ptr] <= i_flags;
        end
    end

endmodule

>>> hdl/tpc_back.sv
module tpc_back #(
    parameter int SAMPLE_WIDTH  = tpc_pkg::SAMPLE_WIDTH,
    parameter int FRACTION_BITS = tpc_pkg::FRACTION_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_queue_valid,
    input  logic [2*SAMPLE_WIDTH+1:0]              i_queue_data,
    input  tpc_pkg::t_flags                        i_queue_flags,
    output logic                                   o_pop,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [tpc_pkg::INDEX_W-1:0]     o_index_value,
    output logic [tpc_pkg::STATUS_W-1:0]           o_status
);

    localparam int ACC_W  = tpc_pkg::ACC_W;
    localparam int IW     = tpc_pkg::INDEX_W;
    localparam int RES_W  = SAMPLE_WIDTH + 2;
    localparam int PN_W   = SAMPLE_WIDTH + RES_W;
    localparam int PD_W   = 2 * SAMPLE_WIDTH;
    localparam int DVD_W  = ACC_W + FRACTION_BITS;
    localparam int CNT_W  = $clog2(DVD_W + 1);
    localparam int Q_W    = IW + 1;

    localparam logic [2:0] S_ACC   = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [Q_W-1:0] LIM_POS = Q_W'(tpc_pkg::INDEX_MAX);
    localparam logic [Q_W-1:0] LIM_NEG = LIM_POS + 1'b1;

    logic [2:0]                     r_state;
    logic                           r_m_valid;
    tpc_pkg::t_flags                r_m_flags;
    logic signed [PN_W-1:0]         r_pn;
    logic signed [PD_W-1:0]         r_pd;
    logic [ACC_W-1:0]               r_num;
    logic [ACC_W-1:0]               r_den;
    logic                           r_neg;
    logic [ACC_W-1:0]               r_div;
    logic [ACC_W-1:0]               r_rem;
    logic [DVD_W-1:0]               r_dvd;
    logic [Q_W-1:0]                 r_q;
    logic                           r_ovf;
    logic [CNT_W-1:0]               r_cnt;
    logic signed [IW-1:0]           r_res_index;
    logic [tpc_pkg::STATUS_W-1:0]   r_res_status;
    logic                           r_out_valid;
    logic signed [IW-1:0]           r_out_index;
    logic [tpc_pkg::STATUS_W-1:0]   r_out_status;

    logic signed [SAMPLE_WIDTH-1:0] q_pc1;
    logic signed [RES_W-1:0]        q_resid;
    logic                           no_support;
    logic [ACC_W-1:0]               mag;
    logic [ACC_W:0]                 rem_sh;
    logic [ACC_W:0]                 diff;
    logic                           ge;
    logic [Q_W-1:0]                 limit;
    logic                           sat;
    logic [Q_W-1:0]                 q_sel;
    logic [Q_W-1:0]                 q_signed;
    logic                           out_free;

    assign q_pc1   = signed'(i_queue_data[2*SAMPLE_WIDTH+1 -: SAMPLE_WIDTH]);
    assign q_resid = signed'(i_queue_data[RES_W-1:0]);

    // hold intake once the image's last voxel is in the multiplier stage
    assign o_pop = i_queue_valid && (r_state == S_ACC) && !(r_m_valid && r_m_flags.last);

    assign no_support = r_den[ACC_W-1] || (r_den == '0);
    assign mag        = r_num[ACC_W-1] ? (~r_num + 1'b1) : r_num;

    assign rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign ge     = !diff[ACC_W];

    assign limit    = r_neg ? LIM_NEG : LIM_POS;
    assign sat      = r_ovf || (r_q > limit);
    assign q_sel    = sat ? limit : r_q;
    assign q_signed = r_neg ? (~q_sel + 1'b1) : q_sel;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pn      <= q_pc1 * q_resid;
            r_pd      <= q_pc1 * q_pc1;
            r_m_flags <= i_queue_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_num   <= '0;
            r_den   <= '0;
        end else begin
            case (r_state)
                S_ACC: begin
                    if (r_m_valid) begin
                        if (!r_m_flags.skip) begin
                            r_num <= r_num + ACC_W'(r_pn);
                            r_den <= r_den + ACC_W'(r_pd);
                        end
                        if (r_m_flags.last) begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_num   <= '0;
                    r_den   <= '0;
                    r_state <= no_support ? S_DONE : S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_ACC;
                    end
                end
                default: begin
                    r_state <= S_ACC;
                end
            endcase
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_SETUP: begin
                r_neg        <= r_num[ACC_W-1];
                r_div        <= r_den;
                r_rem        <= '0;
                r_dvd        <= DVD_W'(mag) << FRACTION_BITS;
                r_q          <= '0;
                r_ovf        <= 1'b0;
                r_cnt        <= CNT_W'(DVD_W);
                r_res_index  <= '0;
                r_res_status <= tpc_pkg::ST_NO_SUPPORT;
            end
            S_DIV: begin
                r_rem <= ge ? diff[ACC_W-1:0] : rem_sh[ACC_W-1:0];
                r_dvd <= r_dvd << 1;
                r_q   <= {r_q[Q_W-2:0], ge};
                r_ovf <= r_ovf || r_q[Q_W-1];
                r_cnt <= r_cnt - 1'b1;
            end
            S_FIN: begin
                r_res_index  <= signed'(q_signed[IW-1:0]);
                r_res_status <= sat ? tpc_pkg::ST_SATURATED : tpc_pkg::ST_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_index  <= r_res_index;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_index_value = r_out_index;
    assign o_status      = r_out_status;

endmodule

>>> hdl/template_projection_coefficient_unit.sv
// result: the sums of an image are divided once its last voxel is accepted, by the bit-serial divider,
//   one quotient bit per cycle over 64 + FRACTION_BITS bits
// throughput: one voxel per cycle within an image; voxels of the next image fill the queue
//   and then wait while the previous image is divided and its result waits for i_out_ready
// reset: synchronous active-low i_rst_n clears both sums, the queue and all valid flags
module template_projection_coefficient_unit #(
    parameter int SAMPLE_WIDTH  = tpc_pkg::SAMPLE_WIDTH,
    parameter int FRACTION_BITS = tpc_pkg::FRACTION_BITS,
    parameter int QUEUE_DEPTH   = tpc_pkg::QUEUE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_image_value,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_mean_value,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_first_component,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_second_component,
    input  logic                                   i_skip_voxel,
    input  logic                                   i_last_voxel,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [tpc_pkg::INDEX_W-1:0]     o_index_value,
    output logic [tpc_pkg::STATUS_W-1:0]           o_status
);

    localparam int DATA_W = 2 * SAMPLE_WIDTH + 2;

    logic                  push;
    logic                  queue_full;
    logic [DATA_W-1:0]     push_data;
    tpc_pkg::t_flags       push_flags;
    logic                  queue_valid;
    logic                  pop;
    logic [DATA_W-1:0]     queue_data;
    tpc_pkg::t_flags       queue_flags;

    tpc_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_image_value      (i_image_value),
        .i_mean_value       (i_mean_value),
        .i_first_component  (i_first_component),
        .i_second_component (i_second_component),
        .i_skip_voxel       (i_skip_voxel),
        .i_last_voxel       (i_last_voxel),
        .o_push             (push),
        .i_queue_full       (queue_full),
        .o_push_data        (push_data),
        .o_push_flags       (push_flags)
    );

    tpc_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_flags (push_flags),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (pop),
        .o_data  (queue_data),
        .o_flags (queue_flags)
    );

    tpc_back #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_valid (queue_valid),
        .i_queue_data  (queue_data),
        .i_queue_flags (queue_flags),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_index_value (o_index_value),
        .o_status      (o_status)
    );

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_no_support_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == tpc_pkg::ST_NO_SUPPORT |-> o_index_value == '0)
        else $error("no-support result with nonzero index");

    a_saturated_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == tpc_pkg::ST_SATURATED |->
            (o_index_value == tpc_pkg::INDEX_MAX || o_index_value == tpc_pkg::INDEX_MIN))
        else $error("saturated result not at a bound");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !queue_full)
        else $error("queue written while full");

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW = tpc_pkg::SAMPLE_WIDTH;
    localparam int FB = tpc_pkg::FRACTION_BITS;
    localparam int IW = tpc_pkg::INDEX_W;

    // divider latency of the block, taken twice over
    localparam int DRAIN_CYCLES   = 2 * (FB + 70);
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

    typedef struct packed {
        logic signed [SW-1:0] image;
        logic signed [SW-1:0] mean;
        logic signed [SW-1:0] first;
        logic signed [SW-1:0] second;
        logic                 skip;
        logic                 last;
    } t_voxel;

    typedef struct packed {
        logic signed [IW-1:0]           index;
        logic [tpc_pkg::STATUS_W-1:0]   status;
    } t_coeff;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic signed [SW-1:0]          i_image_value;
    logic signed [SW-1:0]          i_mean_value;
    logic signed [SW-1:0]          i_first_component;
    logic signed [SW-1:0]          i_second_component;
    logic                          i_skip_voxel;
    logic                          i_last_voxel;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [IW-1:0]          o_index_value;
    logic [tpc_pkg::STATUS_W-1:0]  o_status;

    logic [63:0] numerator_acc;
    logic [63:0] denominator_acc;
    t_coeff      expected_coeffs[$];
    int          mismatch_count;
    int          sender_idle_pct;
    int          receiver_idle_pct;
    int          stalled_cycles;

    template_projection_coefficient_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_image_value      (i_image_value),
        .i_mean_value       (i_mean_value),
        .i_first_component  (i_first_component),
        .i_second_component (i_second_component),
        .i_skip_voxel       (i_skip_voxel),
        .i_last_voxel       (i_last_voxel),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_index_value      (o_index_value),
        .o_status           (o_status)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // ratio of the sums, q12, truncated toward zero and clamped to the index range
    function automatic t_coeff project_coeff(logic [63:0] num, logic [63:0] den);
        t_coeff       c;
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] quot;
        logic [127:0] limit;
        c.index  = '0;
        c.status = tpc_pkg::ST_OK;
        if (den[63] || den == 64'd0) begin
            c.status = tpc_pkg::ST_NO_SUPPORT;
            return c;
        end
        neg   = num[63];
        mag   = neg ? -num : num;
        quot  = ({64'd0, mag} << FB) / {64'd0, den};
        limit = neg ? (128'd1 << (IW - 1)) : ((128'd1 << (IW - 1)) - 128'd1);
        if (quot > limit) begin
            quot     = limit;
            c.status = tpc_pkg::ST_SATURATED;
        end
        c.index = neg ? -quot[IW-1:0] : quot[IW-1:0];
        return c;
    endfunction

    always @(posedge i_clk) begin
        logic signed [63:0] img64;
        logic signed [63:0] mean64;
        logic signed [63:0] first64;
        logic signed [63:0] second64;
        t_coeff             want;
        if (!i_rst_n) begin
            numerator_acc   = '0;
            denominator_acc = '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (!i_skip_voxel) begin
                    img64    = 64'(i_image_value);
                    mean64   = 64'(i_mean_value);
                    first64  = 64'(i_first_component);
                    second64 = 64'(i_second_component);
                    numerator_acc   = numerator_acc + first64 * (img64 - mean64 - second64);
                    denominator_acc = denominator_acc + first64 * first64;
                end
                if (i_last_voxel) begin
                    expected_coeffs.push_back(project_coeff(numerator_acc, denominator_acc));
                    numerator_acc   = '0;
                    denominator_acc = '0;
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_coeffs.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual index %0d status %0d",
                             $time, o_index_value, o_status);
                    mismatch_count++;
                end else begin
                    want = expected_coeffs.pop_front();
                    if (o_index_value !== want.index) begin
                        $display("%0t: index mismatch, expected %0d actual %0d",
                                 $time, want.index, o_index_value);
                        mismatch_count++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, o_status);
                        mismatch_count++;
                    end
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL template_projection_coefficient_unit");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // valid stays high after acceptance; the next item or release_input takes over
    task automatic send_voxel(input t_voxel v);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_image_value      <= v.image;
        i_mean_value       <= v.mean;
        i_first_component  <= v.first;
        i_second_component <= v.second;
        i_skip_voxel       <= v.skip;
        i_last_voxel       <= v.last;
        i_in_valid         <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_voxel make_voxel(logic signed [SW-1:0] image,
                                          logic signed [SW-1:0] mean,
                                          logic signed [SW-1:0] first,
                                          logic signed [SW-1:0] second,
                                          logic skip, logic last);
        t_voxel v;
        v.image  = image;
        v.mean   = mean;
        v.first  = first;
        v.second = second;
        v.skip   = skip;
        v.last   = last;
        return v;
    endfunction

    function automatic logic signed [SW-1:0] pick_sample();
        logic signed [SW-1:0] s;
        case ($urandom_range(9))
            0:       s = S_MAX;
            1:       s = S_MIN;
            2:       s = SW'(int'($urandom_range(31)) - 16);
            default: s = SW'($urandom);
        endcase
        return s;
    endfunction

    task automatic send_random_image(input int len);
        t_voxel v;
        logic   small_first;
        int     skip_pct;
        int     k;
        // small first component pushes the ratio into saturation or no support
        small_first = ($urandom_range(4) == 0);
        skip_pct    = ($urandom_range(3) == 0) ? 60 : 8;
        for (k = 0; k < len; k++) begin
            v.image  = pick_sample();
            v.mean   = pick_sample();
            v.first  = small_first ? SW'($urandom_range(6) - 3) : pick_sample();
            v.second = pick_sample();
            v.skip   = ($urandom_range(99) < skip_pct);
            v.last   = (k == len - 1);
            send_voxel(v);
        end
    endtask

    task automatic wait_for_results();
        while (expected_coeffs.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_corner_voxels();
        send_voxel(make_voxel(S_MAX, S_MIN, S_MAX, S_MIN, 1'b0, 1'b1));
        send_voxel(make_voxel(S_MIN, S_MAX, S_MIN, S_MAX, 1'b0, 1'b1));
        // skipped last voxel with nothing accumulated
        send_voxel(make_voxel(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1, 1'b1));
        // zero first component leaves the denominator at zero
        send_voxel(make_voxel(16'sd100, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1));
        send_voxel(make_voxel(S_MAX, S_MIN, 16'sd1, S_MIN, 1'b0, 1'b1));
        send_voxel(make_voxel(S_MIN, S_MAX, 16'sd1, S_MAX, 1'b0, 1'b1));
        // exactly the negative bound, then one step over the positive bound
        send_voxel(make_voxel(-16'sd2048, 16'sd0, 16'sd1, 16'sd0, 1'b0, 1'b1));
        send_voxel(make_voxel(16'sd2048, 16'sd0, 16'sd1, 16'sd0, 1'b0, 1'b1));
        send_voxel(make_voxel(16'sd2047, 16'sd0, 16'sd1, 16'sd0, 1'b0, 1'b1));
        send_voxel(make_voxel(16'sd0, 16'sd0, S_MAX, 16'sd0, 1'b0, 1'b1));
        // multi-voxel image, skipped voxels in the middle and at the end
        send_voxel(make_voxel(16'sd4096, 16'sd0, 16'sd4096, 16'sd0, 1'b0, 1'b0));
        send_voxel(make_voxel(S_MIN, S_MAX, S_MIN, S_MIN, 1'b1, 1'b0));
        send_voxel(make_voxel(-16'sd4096, 16'sd1000, -16'sd2048, 16'sd500, 1'b0, 1'b0));
        send_voxel(make_voxel(S_MAX, S_MIN, S_MAX, S_MAX, 1'b1, 1'b1));
        // every voxel skipped
        send_voxel(make_voxel(16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b1, 1'b0));
        send_voxel(make_voxel(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b1));
        send_voxel(make_voxel(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, 1'b0));
        send_voxel(make_voxel(-16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b0, 1'b1));
        release_input();
    endtask

    task automatic test_random_images(input int voxel_budget);
        int sent;
        int len;
        sent = 0;
        while (sent < voxel_budget) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            send_random_image(len);
            sent += len;
        end
        release_input();
    endtask

    task automatic test_pause_until_drained();
        send_random_image(5);
        release_input();
        wait_for_results();
        send_random_image(3);
        send_random_image(1);
        release_input();
    endtask

    initial begin
        mismatch_count     = 0;
        stalled_cycles     = 0;
        sender_idle_pct    = 31;
        receiver_idle_pct  = 73;
        i_rst_n            <= 1'b0;
        i_in_valid         <= 1'b0;
        i_out_ready        <= 1'b0;
        i_image_value      <= '0;
        i_mean_value       <= '0;
        i_first_component  <= '0;
        i_second_component <= '0;
        i_skip_voxel       <= 1'b0;
        i_last_voxel       <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_voxels();
        test_random_images(250);

        sender_idle_pct   = 73;
        receiver_idle_pct = 31;
        test_pause_until_drained();
        test_random_images(250);

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_images(250);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_coeffs.size() == 0) begin
            $display("PASS template_projection_coefficient_unit");
        end else begin
            $display("FAIL template_projection_coefficient_unit");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/tpc_pkg.sv
hdl/tpc_front.sv
hdl/tpc_queue.sv
hdl/tpc_back.sv
hdl/template_projection_coefficient_unit.sv
tb/tb.sv
